>>> hdl/psdm_pkg.sv
// Shared types and constants for the pairwise SNP distance matrix unit.
package psdm_pkg;

    localparam int DEF_MAX_SEQUENCES = 8;
    localparam int DEF_COUNT_BITS    = 32;

    localparam int SYM_BITS    = 8;
    localparam int COLUMN_BITS = 64;
    localparam int SEQ_BITS    = 3;
    localparam int NUM_BITS    = 4;
    localparam int DIFF_BITS   = 32;

    localparam logic [NUM_BITS-1:0] CFG_RESET = 4'd8;
    localparam logic [NUM_BITS-1:0] MIN_ACTIVE = 4'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } psdm_step_t;

endpackage

>>> hdl/psdm_col_if.sv
// Column item channel: one symbol per sequence plus the last-column flag.
interface psdm_col_if import psdm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COLUMN_BITS-1:0] column_symbols;
    logic                   last_column;

    modport source (output valid, output column_symbols, output last_column, input ready);
    modport sink   (input valid, input column_symbols, input last_column, output ready);
endinterface

>>> hdl/psdm_pair_if.sv
// Pair result channel: pair indices, difference count and last-pair flag.
interface psdm_pair_if import psdm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEQ_BITS-1:0]  first_sequence;
    logic [SEQ_BITS-1:0]  second_sequence;
    logic [DIFF_BITS-1:0] difference_count;
    logic                 last_pair;

    modport source (output valid, output first_sequence, output second_sequence,
                     output difference_count, output last_pair, input ready);
    modport sink   (input valid, input first_sequence, input second_sequence,
                     input difference_count, input last_pair, output ready);
endinterface

>>> hdl/psdm_counter_bank.sv
// Per-pair saturating difference counters with snapshot buffer for readout.
module psdm_counter_bank import psdm_pkg::*; #(
    parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    localparam int PAIRS        = MAX_SEQUENCES * (MAX_SEQUENCES - 1) / 2,
    localparam int SLOT_W       = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psdm_step_t             step,
    input  logic [COLUMN_BITS-1:0] symbols,
    input  logic [NUM_BITS-1:0]    n_eff,
    input  logic [SLOT_W-1:0]      rd_slot,
    output logic [COUNT_BITS-1:0]  rd_count
);

    logic [COUNT_BITS-1:0] cnt_reg  [PAIRS];
    logic [COUNT_BITS-1:0] cnt_next [PAIRS];
    logic [COUNT_BITS-1:0] snap_reg [PAIRS];
    logic [PAIRS-1:0]      inc;

    for (genvar gi = 0; gi < MAX_SEQUENCES - 1; gi++)
    begin : g_row
        for (genvar gj = gi + 1; gj < MAX_SEQUENCES; gj++)
        begin : g_col
            localparam int S = gi * MAX_SEQUENCES - gi * (gi + 1) / 2 + gj - gi - 1;
            assign inc[S] = (NUM_BITS'(gj) < n_eff)
                && (symbols[SYM_BITS*gi +: SYM_BITS] != symbols[SYM_BITS*gj +: SYM_BITS])
                && (cnt_reg[S] != {COUNT_BITS{1'b1}});
        end
    end

    always_comb
    begin
        for (int k = 0; k < PAIRS; k++)
        begin
            cnt_next[k] = cnt_reg[k] + COUNT_BITS'(inc[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (step.valid)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                cnt_reg[k] <= step.last ? '0 : cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid && step.last)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                snap_reg[k] <= cnt_next[k];
            end
        end
    end

    assign rd_count = snap_reg[rd_slot];

endmodule

>>> hdl/pairwise_snp_distance_matrix_unit.sv
// Top level of the pairwise SNP distance matrix unit.
//
//  channel  dir  handshake        payload
//  col      in   valid/ready      column_symbols[63:0], last_column
//  pair     out  valid/ready      first_sequence, second_sequence, difference_count, last_pair
//  cfg      in   cfg_we           cfg_wdata[3:0] = active_sequences
//
// One column item per cycle unless a last column is held; counters update from the input register.
// A last column copies the counts into a snapshot buffer and clears the counters,
// so columns keep flowing as the readout drains one pair per cycle whenever pair.ready is high.
// A second last column stalls in the input register until the readout finishes.
// rst_n clears counters, readout state and sets active_sequences to 8.
module pairwise_snp_distance_matrix_unit import psdm_pkg::*; #(
    parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    psdm_col_if.sink            col,
    psdm_pair_if.source         pair,
    input  logic                cfg_we,
    input  logic [NUM_BITS-1:0] cfg_wdata
);

    localparam int PAIRS  = MAX_SEQUENCES * (MAX_SEQUENCES - 1) / 2;
    localparam int SLOT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam logic [NUM_BITS-1:0] MAX_N = NUM_BITS'(MAX_SEQUENCES);

    logic [NUM_BITS-1:0]    active_reg;
    logic [NUM_BITS-1:0]    n_eff;

    logic                   stg_valid_reg;
    logic                   stg_last_reg;
    logic [COLUMN_BITS-1:0] stg_sym_reg;
    logic                   consume;
    logic                   snap;
    psdm_step_t             step;

    logic                   rd_busy_reg, rd_busy_next;
    logic [SEQ_BITS-1:0]    rd_i_reg, rd_i_next;
    logic [SEQ_BITS-1:0]    rd_j_reg, rd_j_next;
    logic [SLOT_W-1:0]      rd_slot_reg, rd_slot_next;
    logic [COUNT_BITS-1:0]  rd_count;
    logic                   rd_last;
    logic                   take;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (active_reg > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else if (active_reg < MIN_ACTIVE)
        begin
            n_eff = MIN_ACTIVE;
        end
        else
        begin
            n_eff = active_reg;
        end
    end

    // input register
    assign consume   = stg_valid_reg && !(stg_last_reg && rd_busy_reg);
    assign snap      = consume && stg_last_reg;
    assign col.ready = !stg_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (col.ready)
        begin
            stg_valid_reg <= col.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col.ready && col.valid)
        begin
            stg_sym_reg  <= col.column_symbols;
            stg_last_reg <= col.last_column;
        end
    end

    assign step.valid = consume;
    assign step.last  = stg_last_reg;

    psdm_counter_bank #(
        .MAX_SEQUENCES (MAX_SEQUENCES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .symbols  (stg_sym_reg),
        .n_eff    (n_eff),
        .rd_slot  (rd_slot_reg),
        .rd_count (rd_count)
    );

    // readout sequencing
    assign rd_last = (NUM_BITS'(rd_i_reg) + 4'd2 == n_eff)
                  && (NUM_BITS'(rd_j_reg) + 4'd1 == n_eff);
    assign take    = rd_busy_reg && pair.ready;

    always_comb
    begin
        rd_busy_next = rd_busy_reg;
        rd_i_next    = rd_i_reg;
        rd_j_next    = rd_j_reg;
        rd_slot_next = rd_slot_reg;
        if (snap)
        begin
            rd_busy_next = 1'b1;
            rd_i_next    = '0;
            rd_j_next    = SEQ_BITS'(1);
            rd_slot_next = '0;
        end
        else if (take)
        begin
            if (rd_last)
            begin
                rd_busy_next = 1'b0;
            end
            else if (NUM_BITS'(rd_j_reg) + 4'd1 < n_eff)
            begin
                rd_j_next    = rd_j_reg + SEQ_BITS'(1);
                rd_slot_next = rd_slot_reg + SLOT_W'(1);
            end
            else
            begin
                rd_i_next    = rd_i_reg + SEQ_BITS'(1);
                rd_j_next    = rd_i_reg + SEQ_BITS'(2);
                rd_slot_next = rd_slot_reg + SLOT_W'(MAX_N - n_eff + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_busy_reg <= 1'b0;
            rd_i_reg    <= '0;
            rd_j_reg    <= '0;
            rd_slot_reg <= '0;
        end
        else
        begin
            rd_busy_reg <= rd_busy_next;
            rd_i_reg    <= rd_i_next;
            rd_j_reg    <= rd_j_next;
            rd_slot_reg <= rd_slot_next;
        end
    end

    assign pair.valid            = rd_busy_reg;
    assign pair.first_sequence   = rd_i_reg;
    assign pair.second_sequence  = rd_j_reg;
    assign pair.difference_count = DIFF_BITS'(rd_count);
    assign pair.last_pair        = rd_last;

    // checks
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        pair.valid |-> (pair.first_sequence < pair.second_sequence))
        else $error("pair indices out of order");

    a_readout_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rd_busy_reg) |-> $past(snap))
        else $error("readout started without a last column");

    a_plain_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !stg_last_reg) |-> col.ready)
        else $error("ordinary column stalled the input");

    a_readout_end: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rd_last) |=> !rd_busy_reg)
        else $error("readout continued past the last pair");

endmodule

>>> bench/tb_pairwise_snp_distance_matrix_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pairwise SNP distance matrix unit.
module tb_pairwise_snp_distance_matrix_unit;
    import psdm_pkg::*;

    localparam int MAX_SEQ         = DEF_MAX_SEQUENCES;
    localparam int PAIR_SLOTS      = MAX_SEQ * (MAX_SEQ - 1) / 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [DIFF_BITS-1:0] COUNT_LIMIT =
        {DIFF_BITS{1'b1}} >> (DIFF_BITS - DEF_COUNT_BITS);
    localparam logic [79:0] ALPHABET = "ACGTacgtN-";

    typedef struct packed {
        logic [COLUMN_BITS-1:0] symbols;
        logic                   last;
    } column_item_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0]  first;
        logic [SEQ_BITS-1:0]  second;
        logic [DIFF_BITS-1:0] count;
        logic                 last;
    } pair_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [NUM_BITS-1:0] cfg_wdata = '0;

    psdm_col_if  col_ch ();
    psdm_pair_if pair_ch ();

    pairwise_snp_distance_matrix_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .col       (col_ch),
        .pair      (pair_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    column_item_t         pending_columns[$];
    pair_result_t         expected_pairs[$];
    logic [DIFF_BITS-1:0] pair_counts[PAIR_SLOTS] = '{default: '0};
    logic [NUM_BITS-1:0]  active_setting = CFG_RESET;

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    logic        hold_off_start = 1'b0;
    int unsigned hold_remaining;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;
    int unsigned columns_accepted = 0;
    int unsigned pairs_checked = 0;
    int unsigned readouts = 0;
    int unsigned register_writes = 0;
    logic        offer_next;
    column_item_t next_column;
    pair_result_t oldest_pair;

    function automatic int unsigned effective_sequences();
        int unsigned n;
        n = active_setting;
        if (n > MAX_SEQ)
            n = MAX_SEQ;
        if (n < 2)
            n = 2;
        return n;
    endfunction

    // count one column into the pair slots; on a last column, queue the readout and clear
    task automatic tally_column(input logic [COLUMN_BITS-1:0] symbols, input logic last);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned slot;
        pair_result_t r;
        n = effective_sequences();
        slot = 0;
        for (i = 0; i < MAX_SEQ - 1; i++)
        begin
            for (j = i + 1; j < MAX_SEQ; j++)
            begin
                if (i < n && j < n && symbols[8*i +: 8] != symbols[8*j +: 8]
                    && pair_counts[slot] != COUNT_LIMIT)
                    pair_counts[slot] = pair_counts[slot] + 1'b1;
                slot++;
            end
        end
        if (last)
        begin
            slot = 0;
            for (i = 0; i < MAX_SEQ - 1; i++)
            begin
                for (j = i + 1; j < MAX_SEQ; j++)
                begin
                    if (i < n && j < n)
                    begin
                        r.first  = SEQ_BITS'(i);
                        r.second = SEQ_BITS'(j);
                        r.count  = pair_counts[slot];
                        r.last   = (i + 2 == n) && (j + 1 == n);
                        expected_pairs.push_back(r);
                    end
                    slot++;
                end
            end
            foreach (pair_counts[s])
                pair_counts[s] = '0;
            readouts++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_ch.valid <= 1'b0;
        end
        else
        begin
            if (col_ch.valid && col_ch.ready)
            begin
                tally_column(col_ch.column_symbols, col_ch.last_column);
                columns_accepted++;
            end
            if (!col_ch.valid || col_ch.ready)
            begin
                offer_next = pending_columns.size() != 0
                             && $urandom_range(99) >= sender_idle_pct;
                if (offer_next)
                begin
                    next_column = pending_columns.pop_front();
                    col_ch.column_symbols <= next_column.symbols;
                    col_ch.last_column    <= next_column.last;
                end
                col_ch.valid <= offer_next;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_remaining <= 0;
        else if (hold_off_start)
            hold_remaining <= HOLD_OFF_CYCLES;
        else if (hold_remaining != 0)
            hold_remaining <= hold_remaining - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_ch.ready <= 1'b0;
        end
        else
        begin
            if (pair_ch.valid && pair_ch.ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("unexpected pair result (%0d,%0d) count %0d",
                           pair_ch.first_sequence, pair_ch.second_sequence,
                           pair_ch.difference_count);
                    failures++;
                end
                else
                begin
                    oldest_pair = expected_pairs.pop_front();
                    if (pair_ch.first_sequence !== oldest_pair.first)
                    begin
                        $error("first_sequence: expected %0d, got %0d",
                               oldest_pair.first, pair_ch.first_sequence);
                        failures++;
                    end
                    if (pair_ch.second_sequence !== oldest_pair.second)
                    begin
                        $error("second_sequence: expected %0d, got %0d",
                               oldest_pair.second, pair_ch.second_sequence);
                        failures++;
                    end
                    if (pair_ch.difference_count !== oldest_pair.count)
                    begin
                        $error("difference_count: expected %0d, got %0d",
                               oldest_pair.count, pair_ch.difference_count);
                        failures++;
                    end
                    if (pair_ch.last_pair !== oldest_pair.last)
                    begin
                        $error("last_pair: expected %0d, got %0d",
                               oldest_pair.last, pair_ch.last_pair);
                        failures++;
                    end
                    pairs_checked++;
                end
            end
            pair_ch.ready <= hold_remaining == 0
                             && $urandom_range(99) >= receiver_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pair results outstanding",
                     cycle_count, expected_pairs.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_column(input logic [COLUMN_BITS-1:0] symbols, input logic last);
        column_item_t c;
        c.symbols = symbols;
        c.last    = last;
        pending_columns.push_back(c);
    endtask

    // sampled mid-cycle so that the edge's own updates are already visible
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_columns.size() != 0 || col_ch.valid || expected_pairs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(input logic [NUM_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        active_setting = value;
        register_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return ALPHABET[8*$urandom_range(9) +: 8];
    endfunction

    function automatic logic [COLUMN_BITS-1:0] random_column(input int unsigned variation);
        logic [COLUMN_BITS-1:0] symbols;
        logic [7:0] base;
        int unsigned k;
        base = pick_symbol();
        for (k = 0; k < MAX_SEQ; k++)
            symbols[8*k +: 8] = ($urandom_range(99) < variation) ? pick_symbol() : base;
        return symbols;
    endfunction

    function automatic logic [NUM_BITS-1:0] pick_setting();
        case ($urandom_range(6))
            0: return 4'd0;
            1: return 4'd2;
            2: return 4'd8;
            3: return 4'd15;
            default: return NUM_BITS'($urandom_range(15));
        endcase
    endfunction

    task automatic push_alignment(input int unsigned columns, input logic close);
        int unsigned c;
        int unsigned variation;
        logic noisy;
        variation = $urandom_range(5, 60);
        noisy = $urandom_range(9) == 0;
        for (c = 0; c < columns; c++)
            push_column(noisy ? {$urandom, $urandom} : random_column(variation),
                        close && c + 1 == columns);
    endtask

    task automatic random_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                                input int unsigned target);
        int unsigned pushed;
        int unsigned len;
        wait_quiet();
        sender_idle_pct    <= sender_pct;
        receiver_stall_pct <= receiver_pct;
        pushed = 0;
        while (pushed < target)
        begin
            if ($urandom_range(2) == 0)
            begin
                wait_quiet();
                write_active(pick_setting());
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            if ($urandom_range(5) == 0)
            begin
                // change the count halfway through an alignment
                push_alignment(len, 1'b0);
                wait_quiet();
                write_active(pick_setting());
                push_alignment(2, 1'b1);
                pushed += len + 2;
            end
            else
            begin
                push_alignment(len, 1'b1);
                pushed += len;
            end
        end
    endtask

    initial begin
        int unsigned a;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset count of eight, extremes of the symbol bytes, case sensitivity
        push_column("AAAAAAAA", 1'b1);
        push_column(64'h0000_0000_0000_0000, 1'b0);
        push_column(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_column(64'hFF00_FF00_FF00_FF00, 1'b0);
        push_column("GgCcAaAa", 1'b0);
        push_column(64'h8000_0000_0000_0080, 1'b0);
        push_column(64'h0102_0408_1020_4080, 1'b1);
        wait_quiet();
        // counts below two act as two, above eight as eight
        write_active(4'd0);
        push_column(64'hFFFF_FFFF_FFFF_00FF, 1'b1);
        push_column(64'h1234_5678_9ABC_DEF0, 1'b1);
        wait_quiet();
        write_active(4'd1);
        push_column(64'h0000_0000_0000_0001, 1'b1);
        wait_quiet();
        write_active(4'd15);
        push_column(64'h0706_0504_0302_0100, 1'b1);
        wait_quiet();
        write_active(4'd9);
        push_column("ACGTACGT", 1'b1);
        wait_quiet();
        // count changed mid-stream; unused bytes ignored; every slot cleared on readout
        write_active(4'd8);
        push_column(64'h0706_0504_0302_0100, 1'b0);
        push_column(64'h0706_0504_0302_0100, 1'b0);
        wait_quiet();
        write_active(4'd3);
        push_column(64'h0123_4567_8941_4141, 1'b0);
        push_column(64'hFEDC_BA98_7641_4241, 1'b1);
        wait_quiet();
        write_active(4'd8);
        push_column("TTTTTTTT", 1'b1);
        wait_quiet();
        write_active(4'd2);
        push_column(64'hFFFF_FFFF_FFFF_FF00, 1'b1);

        random_phase(0, 0, 100);
        random_phase(65, 0, 100);
        random_phase(0, 65, 100);
        random_phase(26, 26, 100);

        // long receiver hold-off while short alignments keep coming
        wait_quiet();
        sender_idle_pct    <= 0;
        receiver_stall_pct <= 0;
        write_active(4'd8);
        @(posedge clk);
        hold_off_start <= 1'b1;
        @(posedge clk);
        hold_off_start <= 1'b0;
        for (a = 0; a < 12; a++)
            push_alignment($urandom_range(1, 3), 1'b1);

        wait_quiet();
        repeat (20) @(posedge clk);
        if (expected_pairs.size() != 0)
        begin
            $error("%0d pair results never arrived", expected_pairs.size());
            failures++;
        end
        $display("Covered %0d columns, %0d readouts, %0d pair results, %0d register writes,",
                 columns_accepted, readouts, pairs_checked, register_writes);
        $display("across idle, sender, receiver and mixed stall phases plus a long hold-off.");
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/psdm_pkg.sv
hdl/psdm_col_if.sv
hdl/psdm_pair_if.sv
hdl/psdm_counter_bank.sv
hdl/pairwise_snp_distance_matrix_unit.sv
bench/tb_pairwise_snp_distance_matrix_unit.sv
